// File: rtl/core/spiking_neuron_core_top_macros.svh
// Assertion macros used by the neuromorphic core controller.
`ifndef SPIKING_NEURON_CORE_TOP_MACROS_SVH
`define SPIKING_NEURON_CORE_TOP_MACROS_SVH

// Same-cycle implication, checked on the core clock outside reset.
`define SNC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("snc check failed");

// Next-cycle implication, checked on the core clock outside reset.
`define SNC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("snc check failed");

`endif

// File: rtl/core/snc_pkg.sv
// Shared types, codes and default sizes of the neuromorphic core.
package snc_pkg;

  localparam int unsigned DefAxonCount  = 256;
  localparam int unsigned DefNeuronCnt  = 256;
  localparam int unsigned DefSpikeDepth = 1024;

  // Command codes carried by the command field.
  localparam logic [2:0] CmdSpike   = 3'd0;
  localparam logic [2:0] CmdEval    = 3'd1;
  localparam logic [2:0] CmdClear   = 3'd2;
  localparam logic [2:0] CmdParam   = 3'd3;
  localparam logic [2:0] CmdSynapse = 3'd4;
  localparam logic [2:0] CmdAxType  = 3'd5;

  // Parameter select codes.
  localparam logic [3:0] SelPotential = 4'd0;
  localparam logic [3:0] SelLastByte  = 4'd8;
  localparam logic [3:0] SelDestAxon  = 4'd9;
  localparam logic [3:0] SelDestCore  = 4'd10;

  // Byte lanes of the parameter word.
  localparam int unsigned ByteReset  = 0;
  localparam int unsigned ByteWeight = 1;
  localparam int unsigned ByteLeak   = 5;
  localparam int unsigned BytePosThr = 6;
  localparam int unsigned ByteNegThr = 7;

  // Commands from controller to datapath.
  typedef struct packed {
    logic take;      // input word accepted this cycle
    logic acc_init;  // load accumulator, rewind list walk
    logic walk;      // issue one list entry
    logic finish;    // apply leak, compare, write back, emit result
  } snc_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic list_empty;
    logic walk_last;
    logic neuron_ok;
    logic out_busy;
  } snc_sts_t;

endpackage

// File: rtl/core/snc_ctrl.sv
// Controller state machine sequencing the neuron evaluation.
`include "spiking_neuron_core_top_macros.svh"

module snc_ctrl
  import snc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] command_i,
  input  snc_sts_t   sts_i,
  output snc_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_WALK, S_DRAIN1, S_DRAIN2, S_FINAL
  } state_e;

  state_e state_q, state_d;
  logic   take;
  logic   fin_go;

  assign in_stall_o = (state_q != S_IDLE);
  assign take       = in_valid_i && !in_stall_o;
  assign fin_go     = (state_q == S_FINAL) && !sts_i.out_busy;

  // Decode datapath commands from state.
  always_comb begin
    cmd_o          = '0;
    cmd_o.take     = take;
    cmd_o.acc_init = (state_q == S_LOAD);
    cmd_o.walk     = (state_q == S_WALK);
    cmd_o.finish   = fin_go;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (take && command_i == CmdEval) state_d = S_LOAD;
      end
      S_LOAD: begin
        if (!sts_i.neuron_ok || sts_i.list_empty) state_d = S_FINAL;
        else                                      state_d = S_WALK;
      end
      S_WALK: begin
        if (sts_i.walk_last) state_d = S_DRAIN1;
      end
      S_DRAIN1: state_d = S_DRAIN2;
      S_DRAIN2: state_d = S_FINAL;
      S_FINAL: begin
        if (fin_go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `SNC_ASSERT_IMP(a_walk_nonempty, cmd_o.walk, !sts_i.list_empty && sts_i.neuron_ok)
  `SNC_ASSERT_NXT(a_eval_loads, take && command_i == CmdEval, state_q == S_LOAD)
  `SNC_ASSERT_NXT(a_finish_idle, cmd_o.finish, state_q == S_IDLE)
  `SNC_ASSERT_IMP(a_finish_free, cmd_o.finish, !sts_i.out_busy && !cmd_o.take)

endmodule

// File: rtl/core/snc_dp.sv
// Datapath: neuron, synapse and spike list stores, accumulator and result register.
module snc_dp
  import snc_pkg::*;
#(
  parameter int unsigned AXON_COUNT       = DefAxonCount,
  parameter int unsigned NEURON_COUNT     = DefNeuronCnt,
  parameter int unsigned SPIKE_LIST_DEPTH = DefSpikeDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              is_output_core_i,
  input  logic [2:0]        command_i,
  input  logic [7:0]        axon_i,
  input  logic [7:0]        neuron_i,
  input  logic [3:0]        param_select_i,
  input  logic [7:0]        param_value_i,
  input  snc_cmd_t          cmd_i,
  output snc_sts_t          sts_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic              fired_o,
  output logic              forward_spike_o,
  output logic              output_fire_o,
  output logic [7:0]        fired_neuron_o,
  output logic [7:0]        target_axon_o,
  output logic [7:0]        target_core_o,
  output logic signed [7:0] new_potential_o
);

  localparam int unsigned AW = (AXON_COUNT > 1) ? $clog2(AXON_COUNT) : 1;
  localparam int unsigned NW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
  localparam int unsigned IW = $clog2(SPIKE_LIST_DEPTH);
  localparam int unsigned CW = $clog2(SPIKE_LIST_DEPTH + 1);

  // Stores.
  logic [7:0]              pot_mem   [NEURON_COUNT];
  logic [63:0]             par_mem   [NEURON_COUNT];
  logic [15:0]             route_mem [NEURON_COUNT];
  logic [NEURON_COUNT-1:0] syn_mem   [AXON_COUNT];
  logic [1:0]              typ_mem   [AXON_COUNT];
  logic [AW-1:0]           list_mem  [SPIKE_LIST_DEPTH];

  // One valid bit per axon covers both its synapse row and its type.
  logic [AXON_COUNT-1:0]   syn_vld_q;
  logic [NEURON_COUNT-1:0] fired_q;
  logic [CW-1:0]           count_q;
  logic [IW-1:0]           idx_q;
  logic                    out_vld_q;

  // Evaluation registers.
  logic [7:0]  nreg_q;
  logic        nok_q;
  logic [7:0]  pot_rd_q;
  logic [63:0] par_q;
  logic [15:0] route_q;
  logic [7:0]  acc_q;
  logic [AW-1:0] ax_q;
  logic        s1_vld_q, s2_vld_q;
  logic        bit_q, bitv_q;
  logic [1:0]  typ_q;

  // Result registers.
  logic       fired_rq, fwd_rq, ofire_rq;
  logic [7:0] fn_rq, ta_rq, tc_rq, pot_rq;

  logic          ax_ok, n_ok;
  logic [AW-1:0] a_idx;
  logic [NW-1:0] n_idx, nreg_idx;
  logic [NEURON_COUNT-1:0] syn_row;
  logic [1:0]    typ_eff;
  logic [7:0]    weight, leaked, pot_new;
  logic          fire, below;
  logic [2:0]    byte_sel;

  assign ax_ok    = 32'(axon_i) < AXON_COUNT;
  assign n_ok     = 32'(neuron_i) < NEURON_COUNT;
  assign a_idx    = axon_i[AW-1:0];
  assign n_idx    = neuron_i[NW-1:0];
  assign nreg_idx = nreg_q[NW-1:0];
  assign byte_sel = 3'(param_select_i - 4'd1);

  // Fresh synapse row: only the addressed bit may be set.
  always_comb begin
    syn_row        = '0;
    syn_row[n_idx] = param_value_i[0];
  end

  // Write neuron state; evaluation write-back wins the shared port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && nok_q) begin
      pot_mem[nreg_idx] <= pot_new;
    end else if (cmd_i.take && command_i == CmdParam && n_ok
                 && param_select_i == SelPotential) begin
      pot_mem[n_idx] <= param_value_i;
    end
    if (cmd_i.take && command_i == CmdParam && n_ok && param_select_i != SelPotential
        && param_select_i <= SelLastByte) begin
      par_mem[n_idx][8*byte_sel +: 8] <= param_value_i;
    end
    if (cmd_i.take && command_i == CmdParam && n_ok && param_select_i == SelDestAxon) begin
      route_mem[n_idx][7:0] <= param_value_i;
    end
    if (cmd_i.take && command_i == CmdParam && n_ok && param_select_i == SelDestCore) begin
      route_mem[n_idx][15:8] <= param_value_i;
    end
    // Read neuron state on an evaluate.
    if (cmd_i.take && command_i == CmdEval) begin
      pot_rd_q <= pot_mem[n_idx];
      par_q    <= par_mem[n_idx];
      route_q  <= route_mem[n_idx];
      nreg_q   <= neuron_i;
      nok_q    <= n_ok;
    end
  end

  // Write synapse, axon type and spike list; read them along the walk.
  // The first write to an axon also zeroes its other entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && command_i == CmdSynapse && ax_ok && n_ok) begin
      if (syn_vld_q[a_idx]) begin
        syn_mem[a_idx][n_idx] <= param_value_i[0];
      end else begin
        syn_mem[a_idx] <= syn_row;
        typ_mem[a_idx] <= 2'd0;
      end
    end else if (cmd_i.take && command_i == CmdAxType && ax_ok) begin
      typ_mem[a_idx] <= param_value_i[1:0];
      if (!syn_vld_q[a_idx]) syn_mem[a_idx] <= '0;
    end
    if (cmd_i.take && command_i == CmdSpike && ax_ok
        && 32'(count_q) < SPIKE_LIST_DEPTH) begin
      list_mem[count_q[IW-1:0]] <= a_idx;
    end
    ax_q   <= list_mem[idx_q];
    bit_q  <= syn_mem[ax_q][nreg_idx];
    bitv_q <= syn_vld_q[ax_q];
    typ_q  <= typ_mem[ax_q];
  end

  // Weight, leak and threshold compare.
  assign typ_eff = typ_q;
  assign weight  = par_q[8*(ByteWeight + 32'(typ_eff)) +: 8];
  assign leaked  = acc_q + par_q[8*ByteLeak +: 8];
  assign fire    = !sts_o.list_empty
                   && ($signed(leaked) >= $signed(par_q[8*BytePosThr +: 8]));
  assign below   = !sts_o.list_empty
                   && ($signed(leaked) < $signed(par_q[8*ByteNegThr +: 8]));
  always_comb begin
    if (sts_o.list_empty)  pot_new = acc_q;
    else if (fire || below) pot_new = par_q[8*ByteReset +: 8];
    else                   pot_new = leaked;
  end

  // Accumulate connected spikes; build the result word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_init) begin
      acc_q <= pot_rd_q;
    end else if (s2_vld_q && bitv_q && bit_q) begin
      acc_q <= acc_q + weight;
    end
    if (cmd_i.finish) begin
      fired_rq <= nok_q && fire;
      ofire_rq <= nok_q && fire && is_output_core_i;
      fwd_rq   <= nok_q && fire && !is_output_core_i && !fired_q[nreg_idx];
      fn_rq    <= nreg_q;
      pot_rq   <= nok_q ? pot_new : 8'd0;
      if (nok_q && fire && !is_output_core_i && !fired_q[nreg_idx]) begin
        ta_rq <= route_q[7:0];
        tc_rq <= route_q[15:8];
      end else begin
        ta_rq <= 8'd0;
        tc_rq <= 8'd0;
      end
    end
  end

  // Control state: valid bits, fired flags, list count, walk index, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      syn_vld_q <= '0;
      fired_q   <= '0;
      count_q   <= '0;
      idx_q     <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.take && ((command_i == CmdSynapse && ax_ok && n_ok)
                         || (command_i == CmdAxType && ax_ok))) begin
        syn_vld_q[a_idx] <= 1'b1;
      end
      if (cmd_i.take && command_i == CmdClear) begin
        count_q <= '0;
      end else if (cmd_i.take && command_i == CmdSpike && ax_ok
                   && 32'(count_q) < SPIKE_LIST_DEPTH) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.acc_init)  idx_q <= '0;
      else if (cmd_i.walk) idx_q <= idx_q + 1'b1;
      s1_vld_q <= cmd_i.walk;
      s2_vld_q <= s1_vld_q;
      if (cmd_i.finish && nok_q && fire) fired_q[nreg_idx] <= 1'b1;
      if (cmd_i.finish)     out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  // Status back to the controller.
  always_comb begin
    sts_o            = '0;
    sts_o.list_empty = (count_q == '0);
    sts_o.walk_last  = (CW'(idx_q) + 1'b1 == count_q);
    sts_o.neuron_ok  = nok_q;
    sts_o.out_busy   = out_vld_q && out_stall_i;
  end

  assign out_valid_o     = out_vld_q;
  assign fired_o         = fired_rq;
  assign forward_spike_o = fwd_rq;
  assign output_fire_o   = ofire_rq;
  assign fired_neuron_o  = fn_rq;
  assign target_axon_o   = ta_rq;
  assign target_core_o   = tc_rq;
  assign new_potential_o = $signed(pot_rq);

endmodule

// File: rtl/core/spiking_neuron_core_top.sv
// Evaluation goes straight to the final step when the spike list is empty or
// the neuron is out of range, and otherwise walks the spike list and drains
// the read path first; the final step waits while an earlier result word is
// still stalled at the output. The list walk reads one entry per cycle through
// a three-stage read path: list memory, then synapse row and axon type, then
// accumulate. All other commands are taken without stalling the input. The
// result is held in an output register. While an evaluation is running, the
// input stalls. Synapse rows and axon types read as zero until written; one
// valid bit per axon tracks this, the first write to an axon zeroes its other
// entry, and so no clearing pass runs after reset.
module spiking_neuron_core_top
  import snc_pkg::*;
#(
  parameter int unsigned AXON_COUNT       = DefAxonCount,
  parameter int unsigned NEURON_COUNT     = DefNeuronCnt,
  parameter int unsigned SPIKE_LIST_DEPTH = DefSpikeDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        command_i,
  input  logic [7:0]        axon_i,
  input  logic [7:0]        neuron_i,
  input  logic [3:0]        param_select_i,
  input  logic [7:0]        param_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              fired_o,
  output logic              forward_spike_o,
  output logic              output_fire_o,
  output logic [7:0]        fired_neuron_o,
  output logic [7:0]        target_axon_o,
  output logic [7:0]        target_core_o,
  output logic signed [7:0] new_potential_o
);

  snc_cmd_t cmd;
  snc_sts_t sts;
  logic     is_out_q;

  // Hold the output-core flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_out_q <= 1'b0;
    end else if (cfg_we_i) begin
      is_out_q <= cfg_data_i;
    end
  end

  snc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .command_i,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  snc_dp #(
    .AXON_COUNT       (AXON_COUNT),
    .NEURON_COUNT     (NEURON_COUNT),
    .SPIKE_LIST_DEPTH (SPIKE_LIST_DEPTH)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .is_output_core_i (is_out_q),
    .command_i,
    .axon_i,
    .neuron_i,
    .param_select_i,
    .param_value_i,
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_stall_i,
    .out_valid_o,
    .fired_o,
    .forward_spike_o,
    .output_fire_o,
    .fired_neuron_o,
    .target_axon_o,
    .target_core_o,
    .new_potential_o
  );

endmodule

// File: tb/sv/spiking_neuron_core_top_tb.sv
// Self-checking testbench for the integrate-and-fire neuromorphic core.
`timescale 1ns / 100ps

module spiking_neuron_core_top_tb;
  import snc_pkg::*;

  // Command and select codes that the core must ignore
  localparam logic [2:0] CmdUnusedLo = 3'd6;
  localparam logic [2:0] CmdUnusedHi = 3'd7;
  localparam logic [3:0] SelUnusedLo = 4'd11;
  localparam logic [3:0] SelUnusedHi = 4'd15;
  localparam int unsigned PoolAxons  = 16;
  localparam int unsigned DrainCycles = 16;

  typedef struct packed {
    logic       fired;
    logic       fwd;
    logic       ofire;
    logic [7:0] neuron;
    logic [7:0] taxon;
    logic [7:0] tcore;
    logic [7:0] pot;
  } eval_result_t;

  // Predicts each evaluation and holds the outcomes still to arrive
  class neuron_predictor;
    bit            out_core;
    logic [7:0]    potential [256];
    logic [63:0]   params [256];
    logic [15:0]   route [256];
    logic [63:0]   synapse [1024];
    logic [1:0]    ax_type [256];
    bit            fired_seen [256];
    logic [7:0]    spikes [$];
    eval_result_t  pending_evals [$];
    int            errors;
    int            evals_checked;
    int            fires_seen;

    function new();
      out_core = 0;
      errors = 0;
      evals_checked = 0;
      fires_seen = 0;
      foreach (synapse[i]) synapse[i] = '0;
      foreach (ax_type[i]) begin
        ax_type[i] = '0;
        fired_seen[i] = 0;
        potential[i] = '0;
        params[i] = '0;
        route[i] = '0;
      end
    endfunction

    function eval_result_t evaluate(logic [7:0] nrn);
      eval_result_t r;
      logic [7:0] pot;
      int row;
      r = '0;
      r.neuron = nrn;
      pot = potential[nrn];
      // accumulate the weight of every connected spike
      foreach (spikes[i]) begin
        row = int'(spikes[i]) * 4 + int'(nrn) / 64;
        if (synapse[row][int'(nrn) % 64])
          pot += params[nrn][8 * (ByteWeight + int'(ax_type[spikes[i]])) +: 8];
      end
      if (spikes.size() > 0) begin
        pot += params[nrn][8 * ByteLeak +: 8];
        if ($signed(pot) >= $signed(params[nrn][8 * BytePosThr +: 8])) begin
          pot = params[nrn][8 * ByteReset +: 8];
          r.fired = 1;
        end else if ($signed(pot) < $signed(params[nrn][8 * ByteNegThr +: 8])) begin
          pot = params[nrn][8 * ByteReset +: 8];
        end
      end
      potential[nrn] = pot;
      if (r.fired) begin
        if (out_core) begin
          r.ofire = 1;
        end else if (!fired_seen[nrn]) begin
          r.fwd = 1;
          r.taxon = route[nrn][7:0];
          r.tcore = route[nrn][15:8];
        end
        fired_seen[nrn] = 1;
      end
      r.pot = pot;
      return r;
    endfunction

    function void note_word(logic [2:0] cmd, logic [7:0] ax, logic [7:0] nrn,
                            logic [3:0] sel, logic [7:0] val);
      case (cmd)
        CmdSpike:   if (spikes.size() < DefSpikeDepth) spikes.push_back(ax);
        CmdClear:   spikes.delete();
        CmdParam: begin
          if (sel == SelPotential) potential[nrn] = val;
          else if (sel <= SelLastByte) params[nrn][8 * (int'(sel) - 1) +: 8] = val;
          else if (sel == SelDestAxon) route[nrn][7:0] = val;
          else if (sel == SelDestCore) route[nrn][15:8] = val;
        end
        CmdSynapse: synapse[int'(ax) * 4 + int'(nrn) / 64][int'(nrn) % 64] = val[0];
        CmdAxType:  ax_type[ax] = val[1:0];
        CmdEval:    pending_evals.push_back(evaluate(nrn));
        default: ;
      endcase
    endfunction

    function void report(string field, int e, int a);
      if (e != a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, e, a);
      end
    endfunction

    function void check_eval(eval_result_t got);
      eval_result_t e;
      if (pending_evals.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual %h", $time, got);
        return;
      end
      e = pending_evals.pop_front();
      evals_checked++;
      if (e.fired) fires_seen++;
      report("fired", e.fired, got.fired);
      report("forward_spike", e.fwd, got.fwd);
      report("output_fire", e.ofire, got.ofire);
      report("fired_neuron", e.neuron, got.neuron);
      report("target_axon", e.taxon, got.taxon);
      report("target_core", e.tcore, got.tcore);
      report("new_potential", $signed(e.pot), $signed(got.pot));
    endfunction
  endclass

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              cfg_we_i = 0;
  logic              cfg_data_i = 0;
  logic              in_valid_i = 0;
  logic              in_stall_o;
  logic [2:0]        command_i = '0;
  logic [7:0]        axon_i = '0;
  logic [7:0]        neuron_i = '0;
  logic [3:0]        param_select_i = '0;
  logic [7:0]        param_value_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 0;
  logic              fired_o;
  logic              forward_spike_o;
  logic              output_fire_o;
  logic [7:0]        fired_neuron_o;
  logic [7:0]        target_axon_o;
  logic [7:0]        target_core_o;
  logic signed [7:0] new_potential_o;

  neuron_predictor predictor = new();
  bit [10:0] init_mask [256];
  int        ready_neurons [$];
  int        words_sent = 0;
  int        burst_left = 0;
  int        stall_left = 0;
  int        stall_mode = 0;

  spiking_neuron_core_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .axon_i         (axon_i),
    .neuron_i       (neuron_i),
    .param_select_i (param_select_i),
    .param_value_i  (param_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .fired_o        (fired_o),
    .forward_spike_o(forward_spike_o),
    .output_fire_o  (output_fire_o),
    .fired_neuron_o (fired_neuron_o),
    .target_axon_o  (target_axon_o),
    .target_core_o  (target_core_o),
    .new_potential_o(new_potential_o)
  );

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  // Stall the result side in modes: none, light, heavy
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Check every accepted result word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      predictor.check_eval({fired_o, forward_spike_o, output_fire_o, fired_neuron_o,
                            target_axon_o, target_core_o, new_potential_o});
  end

  // Drive one input word, with bursts and random gaps, and hold it until taken
  task automatic send_word(logic [2:0] cmd, logic [7:0] ax, logic [7:0] nrn,
                           logic [3:0] sel, logic [7:0] val);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    axon_i         <= ax;
    neuron_i       <= nrn;
    param_select_i <= sel;
    param_value_i  <= val;
    do @(posedge clk_i); while (in_stall_o);
    predictor.note_word(cmd, ax, nrn, sel, val);
    words_sent++;
    if (cmd == CmdParam && sel <= SelDestCore) begin
      if (init_mask[nrn] != '1) begin
        init_mask[nrn][sel] = 1'b1;
        if (init_mask[nrn] == '1) ready_neurons.push_back(int'(nrn));
      end
    end
  endtask

  // Hold the sender until every pending evaluation has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (predictor.pending_evals.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_out_core(bit v);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    predictor.out_core = v;
  endtask

  task automatic init_neuron(int n);
    logic [7:0] v;
    for (int s = 0; s <= int'(SelDestCore); s++) begin
      v = $urandom_range(0, 255);
      // bias thresholds so both fires and silent resets occur
      if (s == 1 + BytePosThr) v = $urandom_range(0, 40);
      if (s == 1 + ByteNegThr) v = 8'(-$urandom_range(0, 40));
      send_word(CmdParam, '0, 8'(n), 4'(s), v);
    end
    repeat (4) send_word(CmdSynapse, 8'($urandom_range(0, PoolAxons - 1)), 8'(n), '0, 8'hFF);
  endtask

  function automatic logic [7:0] pick_ready();
    return 8'(ready_neurons[$urandom_range(0, ready_neurons.size() - 1)]);
  endfunction

  function automatic logic [7:0] pick_axon();
    return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, PoolAxons - 1));
  endfunction

  // One timestep: clear, a list of spikes with loads and ignored commands mixed in, then evaluations
  task automatic timestep();
    int nsp;
    int kind;
    send_word(CmdClear, 8'($urandom), 8'($urandom), 4'($urandom), 8'($urandom));
    nsp = $urandom_range(0, 12);
    for (int i = 0; i < nsp; i++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        6: send_word(CmdSynapse, pick_axon(), pick_ready(), '0, 8'($urandom));
        7: send_word(CmdAxType, pick_axon(), 8'($urandom), '0, 8'($urandom));
        8: send_word(CmdParam, '0, pick_ready(), 4'($urandom_range(1, 15)), 8'($urandom));
        9: send_word($urandom_range(0, 1) ? CmdUnusedLo : CmdUnusedHi, 8'($urandom),
                     8'($urandom), 4'($urandom), 8'($urandom));
        default: send_word(CmdSpike, pick_axon(), 8'($urandom), 4'($urandom), 8'($urandom));
      endcase
    end
    repeat ($urandom_range(1, 3))
      send_word(CmdEval, 8'($urandom), pick_ready(), 4'($urandom), 8'($urandom));
  endtask

  task automatic random_phase(int words);
    int target;
    target = words_sent + words;
    while (words_sent < target) begin
      if (ready_neurons.size() < 4 || $urandom_range(0, 99) < 6)
        init_neuron($urandom_range(0, 255));
      else
        timestep();
    end
  endtask

  initial begin
    foreach (init_mask[i]) init_mask[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme neuron, empty list, ignored words, type and synapse extremes
    send_word(CmdParam, '0, 8'd255, SelPotential, 8'h7F);
    send_word(CmdParam, '0, 8'd255, 4'd1, 8'h80);
    send_word(CmdParam, '0, 8'd255, 4'd2, 8'hFF);
    send_word(CmdParam, '0, 8'd255, 4'd3, 8'h01);
    send_word(CmdParam, '0, 8'd255, 4'd4, 8'h7F);
    send_word(CmdParam, '0, 8'd255, 4'd5, 8'h80);
    send_word(CmdParam, '0, 8'd255, 4'd6, 8'h00);
    send_word(CmdParam, '0, 8'd255, 4'd7, 8'h7F);
    send_word(CmdParam, '0, 8'd255, SelLastByte, 8'h80);
    send_word(CmdParam, '0, 8'd255, SelDestAxon, 8'hFF);
    send_word(CmdParam, '0, 8'd255, SelDestCore, 8'hAA);
    send_word(CmdEval, '0, 8'd255, '0, '0);
    send_word(CmdSynapse, 8'd255, 8'd255, '0, 8'hFF);
    send_word(CmdAxType, 8'd255, '0, '0, 8'hFF);
    send_word(CmdSynapse, 8'd0, 8'd255, '0, 8'hFE);
    send_word(CmdParam, '0, 8'd255, SelUnusedHi, 8'h00);
    send_word(CmdParam, '0, 8'd255, SelUnusedLo, 8'h55);
    send_word(CmdUnusedHi, 8'hFF, 8'hFF, 4'hF, 8'hFF);
    send_word(CmdUnusedLo, '0, '0, '0, '0);
    send_word(CmdSpike, 8'd255, '0, '0, '0);
    send_word(CmdSpike, 8'd0, '0, '0, '0);
    send_word(CmdEval, '0, 8'd255, '0, '0);
    send_word(CmdEval, '0, 8'd255, '0, '0);
    send_word(CmdClear, '0, '0, '0, '0);
    send_word(CmdEval, '0, 8'd255, '0, '0);

    random_phase(220);
    write_out_core(1'b1);
    random_phase(170);
    write_out_core(1'b0);

    // Overfill the spike list so the tail is dropped
    send_word(CmdClear, '0, '0, '0, '0);
    repeat (DefSpikeDepth + 6) send_word(CmdSpike, pick_axon(), '0, '0, '0);
    repeat (2) send_word(CmdEval, '0, pick_ready(), '0, '0);
    send_word(CmdClear, '0, '0, '0, '0);

    random_phase(170);
    write_out_core(1'b1);
    random_phase(150);
    write_out_core(1'b0);
    random_phase(150);

    drain();
    $display("Run covered %0d input words, %0d evaluations checked, %0d fires,",
             words_sent, predictor.evals_checked, predictor.fires_seen);
    $display("on both core roles, with list overflow and ignored commands.");
    if (predictor.errors == 0 && predictor.pending_evals.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
